@@ hw/rtl/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

  // angle constants in unsigned Q32, rounded to nearest
  localparam logic [39:0] K_TWOPI = 40'd26986075409;
  localparam logic [39:0] K_PI    = 40'd13493037705;
  localparam logic [39:0] K_PI_2  = 40'd6746518852;
  localparam logic [39:0] K_PI_4  = 40'd3373259426;
  localparam logic [32:0] K_4PI   = 33'd5468522205;

  localparam int ACC_W   = 44;
  localparam int LANES   = 2;
  localparam int FRONT_N = 15;
  localparam int CELL_N  = 8;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [39:0] x;
    logic [65:0] p;
    logic [32:0] y;
    logic [32:0] z;
    logic        eq;
    logic        odd;
    logic        neg;
    acc_t        acc;
  } lane_t;

  // lane 0 carries the sine, lane 1 the cosine
  typedef lane_t [LANES-1:0] item_t;

  // signed Q40 coefficients, highest order first
  localparam acc_t ODD_C [8] = '{
    44'sd0, 44'sd8, -44'sd1932, 44'sd344545, -44'sd40215962, 44'sd2738217788,
    -44'sd88780629542, 44'sd863554413089
  };
  localparam acc_t EVEN_C [8] = '{
    44'sd0, 44'sd126, -44'sd27060, 44'sd3948193, -44'sd358431870, 44'sd17432035847,
    -44'sd339117025017, 44'sd1099511627776
  };

  function automatic acc_t coef(input logic odd, input logic [2:0] idx);
    return odd ? ODD_C[idx] : EVEN_C[idx];
  endfunction

endpackage

@@ hw/rtl/scp_front.sv @@
`timescale 1ns / 1ps
module scp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  logic [31:0]    angle,
  output logic           dst_valid,
  input  logic           dst_ready,
  output scp_pkg::item_t dst_item
);
  import scp_pkg::*;

  logic [FRONT_N-1:0] v;
  logic [FRONT_N-1:0] en;
  item_t              st  [FRONT_N];
  item_t              nxt [FRONT_N];
  logic [31:0]        mag;

  function automatic logic [32:0] rnd32(input logic [65:0] p);
    logic [65:0] s;
    s = p + 66'h8000_0000;
    return s[64:32];
  endfunction

  always_comb begin
    en[FRONT_N-1] = !v[FRONT_N-1] || dst_ready;
    for (int i = FRONT_N - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign src_ready = en[0];

  always_comb begin
    mag = angle[31] ? (~angle + 32'd1) : angle;
    nxt[0] = '0;
    for (int l = 0; l < LANES; l++) nxt[0][l].x = {mag, 8'b0};
    nxt[0][0].neg = angle[31];
    nxt[0][0].eq  = ({mag, 8'b0} == K_TWOPI);
    for (int i = 1; i < FRONT_N; i++) begin
      nxt[i] = st[i-1];
      unique case (i)
        // restoring reduction by 16, 8, 4, 2 and 1 times two pi
        1, 2, 3, 4, 5: begin
          if (st[i-1][0].x >= (K_TWOPI << (5 - i)))
            nxt[i][0].x = st[i-1][0].x - (K_TWOPI << (5 - i));
        end
        6: begin
          nxt[i][0].x = st[i-1][0].eq ? K_TWOPI : st[i-1][0].x;
          nxt[i][1].x = nxt[i][0].x + K_PI_2;
        end
        7: begin
          if (st[i-1][1].x > K_TWOPI) nxt[i][1].x = st[i-1][1].x - K_TWOPI;
        end
        8: begin
          for (int l = 0; l < LANES; l++) begin
            if (st[i-1][l].x > K_PI) begin
              nxt[i][l].x   = st[i-1][l].x - K_PI;
              nxt[i][l].neg = !st[i-1][l].neg;
            end
          end
        end
        9: begin
          for (int l = 0; l < LANES; l++)
            if (st[i-1][l].x > K_PI_2) nxt[i][l].x = K_PI - st[i-1][l].x;
        end
        10: begin
          for (int l = 0; l < LANES; l++) begin
            nxt[i][l].odd = st[i-1][l].x < K_PI_4;
            if (!nxt[i][l].odd) nxt[i][l].x = K_PI_2 - st[i-1][l].x;
          end
        end
        11: begin
          for (int l = 0; l < LANES; l++)
            nxt[i][l].p = 66'(st[i-1][l].x[32:0]) * 66'(K_4PI);
        end
        12: begin
          for (int l = 0; l < LANES; l++) nxt[i][l].y = rnd32(st[i-1][l].p);
        end
        13: begin
          for (int l = 0; l < LANES; l++)
            nxt[i][l].p = 66'(st[i-1][l].y) * 66'(st[i-1][l].y);
        end
        14: begin
          for (int l = 0; l < LANES; l++) begin
            nxt[i][l].z   = rnd32(st[i-1][l].p);
            nxt[i][l].acc = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= src_valid;
      for (int i = 1; i < FRONT_N; i++) if (en[i]) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRONT_N; i++) if (en[i]) st[i] <= nxt[i];
  end

  assign dst_valid = v[FRONT_N-1];
  assign dst_item  = st[FRONT_N-1];

endmodule

@@ hw/rtl/scp_cell.sv @@
`timescale 1ns / 1ps
module scp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     idx,
  input  logic           last,
  input  logic           src_valid,
  output logic           src_ready,
  input  scp_pkg::item_t src_item,
  output logic           dst_valid,
  input  logic           dst_ready,
  output scp_pkg::item_t dst_item
);
  import scp_pkg::*;

  logic        va, vb, en_a, en_b;
  item_t       a_item, b_item, b_next;
  logic [54:0] plo      [LANES];
  logic [53:0] phi      [LANES];
  logic [54:0] a_plo    [LANES];
  logic [53:0] a_phi    [LANES];
  logic        a_sgn    [LANES];
  logic [42:0] mag      [LANES];
  logic [32:0] mul_op   [LANES];
  logic [75:0] full     [LANES];
  acc_t        res      [LANES];

  assign en_b      = !vb || dst_ready;
  assign en_a      = !va || en_b;
  assign src_ready = en_a;

  // split magnitude times operand into two partial products
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]    = src_item[l].acc[ACC_W-1] ? 43'(-src_item[l].acc) : 43'(src_item[l].acc);
      mul_op[l] = last ? src_item[l].y : src_item[l].z;
      plo[l]    = 55'(mag[l][21:0]) * 55'(mul_op[l]);
      phi[l]    = 54'(mag[l][42:22]) * 54'(mul_op[l]);
    end
  end

  // recombine, round half away from zero, add the coefficient
  always_comb begin
    b_next = a_item;
    for (int l = 0; l < LANES; l++) begin
      full[l] = 76'(a_plo[l]) + (76'(a_phi[l]) << 22) + 76'(32'h8000_0000);
      res[l]  = a_sgn[l] ? -$signed(full[l][75:32]) : $signed(full[l][75:32]);
      if (!(last && !a_item[l].odd))
        b_next[l].acc = res[l] + coef(a_item[l].odd, idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (en_a) va <= src_valid;
      if (en_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_item <= src_item;
      for (int l = 0; l < LANES; l++) begin
        a_plo[l] <= plo[l];
        a_phi[l] <= phi[l];
        a_sgn[l] <= src_item[l].acc[ACC_W-1];
      end
    end
    if (en_b) b_item <= b_next;
  end

  assign dst_valid = vb;
  assign dst_item  = b_item;

endmodule

@@ hw/rtl/scp_back.sv @@
`timescale 1ns / 1ps
module scp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  scp_pkg::item_t src_item,
  output logic           dst_valid,
  input  logic           dst_ready,
  output logic [31:0]    sine,
  output logic [31:0]    cosine
);
  import scp_pkg::*;

  logic        v0, v1, v2, en0, en1, en2;
  logic [42:0] m0   [LANES];
  logic        s0   [LANES];
  logic [30:0] q1   [LANES];
  logic        s1   [LANES];
  logic [33:0] t    [LANES];
  logic [30:0] qn   [LANES];
  logic [31:0] res  [LANES];

  assign en2       = !v2 || dst_ready;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign src_ready = en0;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      t[l]   = 34'((44'(m0[l]) + 44'd512) >> 10);
      qn[l]  = (t[l] > 34'h4000_0000) ? 31'h4000_0000 : t[l][30:0];
      res[l] = s1[l] ? -32'(q1[l]) : 32'(q1[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= src_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (en0) begin
        m0[l] <= src_item[l].acc[ACC_W-1] ? 43'(-src_item[l].acc) : 43'(src_item[l].acc);
        s0[l] <= src_item[l].acc[ACC_W-1] != src_item[l].neg;
      end
      if (en1) begin
        q1[l] <= qn[l];
        s1[l] <= s0[l];
      end
    end
    if (en2) begin
      sine   <= res[0];
      cosine <= res[1];
    end
  end

  assign dst_valid = v2;

endmodule

@@ hw/rtl/sine_cosine_polynomial.sv @@
`timescale 1ns / 1ps
// sine and cosine of a signed Q8.24 angle in radians, results in signed Q2.30
// limited to plus or minus one
//
// request side: src_valid / src_ready with angle; a request is taken on a
// clock edge where both are high
// result side: dst_valid / dst_ready with sine and cosine, held stable while
// dst_valid is high and dst_ready is low
//
// the pipeline has 15 front stages (sign removal, modulo two pi by
// restoring subtraction, folds, scaling by 4/pi and squaring), a row of 8
// polynomial cells of 2 stages each, and 3 output stages for rounding,
// saturation and sign
// throughput is one request per cycle while dst_ready stays high; every
// stage has its own valid and moves whenever the stage after it is empty
// or moving, so empty stages still fill while the receiver stalls, and
// src_ready drops only once all stages hold results
// synchronous reset clears all valid bits; no result appears until a
// request has gone through
module sine_cosine_polynomial (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic [31:0] angle,
  output logic        dst_valid,
  input  logic        dst_ready,
  output logic [31:0] sine,
  output logic [31:0] cosine
);
  import scp_pkg::*;

  // handshake between neighbors in the cell row
  logic  c_valid [CELL_N+1];
  logic  c_ready [CELL_N+1];
  item_t c_item  [CELL_N+1];

  // range reduction, y and z = y*y for both lanes
  scp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .angle     (angle),
    .dst_valid (c_valid[0]),
    .dst_ready (c_ready[0]),
    .dst_item  (c_item[0])
  );

  // horner row: cells 0..6 take one coefficient each, the last cell
  // multiplies by y on the odd polynomial and passes the even one through
  for (genvar j = 0; j < CELL_N; j++) begin : g_cell
    scp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (j == CELL_N - 1 ? 3'd0 : 3'(j + 1)),
      .last      (j == CELL_N - 1),
      .src_valid (c_valid[j]),
      .src_ready (c_ready[j]),
      .src_item  (c_item[j]),
      .dst_valid (c_valid[j+1]),
      .dst_ready (c_ready[j+1]),
      .dst_item  (c_item[j+1])
    );
  end

  // rounding to Q30, saturation, sign and the output register
  scp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .src_valid (c_valid[CELL_N]),
    .src_ready (c_ready[CELL_N]),
    .src_item  (c_item[CELL_N]),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .sine      (sine),
    .cosine    (cosine)
  );

endmodule

@@ hw/rtl/sine_cosine_polynomial_chk.sv @@
`timescale 1ns / 1ps
module sine_cosine_polynomial_chk (
  input logic        clk,
  input logic        rst,
  input logic        src_ready,
  input logic        dst_valid,
  input logic        dst_ready,
  input logic [31:0] sine,
  input logic [31:0] cosine
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(sine) && $stable(cosine))
    else $error("result changed while stalled");

  // results never exceed plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ($signed(sine) <= 32'sd1073741824) && ($signed(sine) >= -32'sd1073741824)
      && ($signed(cosine) <= 32'sd1073741824) && ($signed(cosine) >= -32'sd1073741824))
    else $error("result out of range");

  // a pipeline that drains at the output always takes a request
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!dst_valid || dst_ready) |-> src_ready)
    else $error("request refused while output moves");

  // reset leaves no result behind
  a_reset: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid after reset");

endmodule

bind sine_cosine_polynomial sine_cosine_polynomial_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .src_ready (src_ready),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .sine      (sine),
  .cosine    (cosine)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_ready;
  logic [31:0] angle = '0;
  logic        dst_valid;
  logic        dst_ready = 1'b0;
  logic [31:0] sine;
  logic [31:0] cosine;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sine_cosine_polynomial dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .angle(angle),
    .dst_valid(dst_valid), .dst_ready(dst_ready),
    .sine(sine), .cosine(cosine)
  );

  // q32 angle constants, rounded to nearest
  localparam logic [63:0] TWO_PI  = 64'd26986075409;
  localparam logic [63:0] PI_Q32  = 64'd13493037705;
  localparam logic [63:0] HALF_PI = 64'd6746518852;
  localparam logic [63:0] QTR_PI  = 64'd3373259426;
  localparam logic [63:0] FOUR_OVER_PI = 64'd5468522205;
  localparam logic [63:0] UNIT_Q30 = 64'd1073741824;
  localparam int LATENCY = 34;

  // q40 coefficients, highest order first
  localparam longint ODD_TERMS [8] = '{
    64'sd0, 64'sd8, -64'sd1932, 64'sd344545, -64'sd40215962, 64'sd2738217788,
    -64'sd88780629542, 64'sd863554413089
  };
  localparam longint EVEN_TERMS [8] = '{
    64'sd0, 64'sd126, -64'sd27060, 64'sd3948193, -64'sd358431870, 64'sd17432035847,
    -64'sd339117025017, 64'sd1099511627776
  };

  typedef struct {
    logic [31:0] sin_v;
    logic [31:0] cos_v;
    logic [31:0] ang;
  } trig_pair_t;

  // unsigned product, exact, rounded and shifted down 32
  function automatic logic [63:0] mul_round32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
    return p[95:32];
  endfunction

  // signed q40 times unsigned q32, rounding half away from zero
  function automatic longint scale_signed(longint acc, logic [63:0] z);
    logic [63:0] m;
    logic [63:0] p;
    m = (acc < 0) ? 64'(-acc) : 64'(acc);
    p = mul_round32(m, z);
    return (acc < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint eval_poly(logic odd, logic [63:0] z);
    longint acc;
    acc = odd ? ODD_TERMS[0] : EVEN_TERMS[0];
    for (int i = 1; i < 8; i++)
      acc = scale_signed(acc, z) + (odd ? ODD_TERMS[i] : EVEN_TERMS[i]);
    return acc;
  endfunction

  // sine of a nonnegative q32 magnitude, q30 result
  function automatic logic [31:0] sine_of_mag(logic [63:0] x, logic neg);
    longint r;
    logic [63:0] y, z, m, q;
    logic rneg;
    if (x > TWO_PI) x = x % TWO_PI;
    if (x > PI_Q32) begin
      x = x - PI_Q32;
      neg = !neg;
    end
    if (x > HALF_PI) x = PI_Q32 - x;
    if (x < QTR_PI) begin
      y = mul_round32(x, FOUR_OVER_PI);
      z = mul_round32(y, y);
      r = scale_signed(eval_poly(1'b1, z), y);
    end else begin
      y = mul_round32(HALF_PI - x, FOUR_OVER_PI);
      z = mul_round32(y, y);
      r = eval_poly(1'b0, z);
    end
    rneg = r < 0;
    m = rneg ? 64'(-r) : 64'(r);
    q = (m + 64'd512) >> 10;
    if (q > UNIT_Q30) q = UNIT_Q30;
    if (rneg != neg) q = -q;
    return q[31:0];
  endfunction

  function automatic trig_pair_t predict_trig(logic [31:0] a);
    trig_pair_t t;
    logic [63:0] mag, x, c;
    mag = a[31] ? 64'(33'h1_0000_0000 - {1'b0, a}) : 64'(a);
    x = mag << 8;
    c = (x > TWO_PI) ? x % TWO_PI : x;
    t.ang = a;
    t.sin_v = sine_of_mag(x, a[31]);
    t.cos_v = sine_of_mag(c + HALF_PI, 1'b0);
    return t;
  endfunction

  class trig_scoreboard;
    trig_pair_t pending[$];
    int errors;
    int checked;

    function void note_angle(logic [31:0] a);
      pending.push_back(predict_trig(a));
    endfunction

    function void check_pair(logic [31:0] s, logic [31:0] c);
      trig_pair_t t;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result sine %h cosine %h", $time, s, c);
        errors++;
        return;
      end
      t = pending.pop_front();
      checked++;
      if (s !== t.sin_v) begin
        $display("%0t: angle %h sine expected %h actual %h", $time, t.ang, t.sin_v, s);
        errors++;
      end
      if (c !== t.cos_v) begin
        $display("%0t: angle %h cosine expected %h actual %h", $time, t.ang, t.cos_v, c);
        errors++;
      end
    endfunction
  endclass

  trig_scoreboard board = new();

  // idle rate in percent for each side; zero gives a stretch with no gaps
  int src_idle = 30;
  int dst_idle = 30;
  int hold_cycles = 0;
  int sent = 0;

  // request and result sampling at the rising edge
  always @(posedge clk) begin
    if (!rst && src_valid && src_ready) board.note_angle(angle);
    if (!rst && dst_valid && dst_ready) board.check_pair(sine, cosine);
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // send one request, idling at random first; valid stays up between
  // back to back requests
  task automatic send_angle(logic [31:0] a);
    while ($urandom_range(99) < src_idle) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    angle <= a;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    src_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // random angle: mostly within a few turns, sometimes anything
  function automatic logic [31:0] random_angle();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(210000000)) - 105000000);
      2: return 32'($signed($urandom_range(60000000)) - 30000000);
      default: return $urandom() & 32'h8000_00ff | 32'h0000_0100 * $urandom_range(1);
    endcase
  endfunction

  initial begin
    logic [31:0] special [$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // q8.24 values at and around the fold and reduction boundaries
    // exact two pi, pi, pi/2, pi/4 in q8.24 land near the q32 constants
    special = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                32'hffff_ffff, 32'h0000_0001, 32'h0648_7ed5, 32'h0648_7ed6,
                32'hf9b7_812b, 32'h0324_3f6a, 32'h0324_3f6b, 32'h0192_1fb5,
                32'h0192_1fb6, 32'h00c9_0fda, 32'h00c9_0fdb, 32'h012d_97c8,
                32'h0100_0000, 32'hff00_0000, 32'h5555_5555, 32'haaaa_aaaa,
                32'h0c90_fdaa, 32'hfcdb_c095};
    foreach (special[i]) send_angle(special[i]);
    drain();

    // long receiver hold-off while requests keep coming, so the pipe fills
    src_idle = 0;
    hold_cycles = 80;
    repeat (60) send_angle(random_angle());
    drain();

    // stretch with no idling on either side
    dst_idle = 0;
    repeat (100) send_angle(random_angle());
    drain();

    src_idle = 30;
    dst_idle = 30;
    repeat (470) send_angle(random_angle());
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("checked %0d sine/cosine pairs from %0d angles, incl. fold and wrap edges",
             board.checked, sent);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("testbench failed");
    $finish;
  end

endmodule
